// File: rtl/core/epoch_seconds_to_calendar_unit_macros.svh
// assertion macros for the epoch seconds to calendar unit
// used by the top level only; no other dependencies
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// same-cycle implication, checking disabled while reset is low
`define ESC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("calendar unit check failed");

// next-cycle implication, checking disabled while reset is low
`define ESC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("calendar unit check failed");

`endif

// File: rtl/core/esc_pkg.sv
// types, constants and calendar helpers for the epoch seconds to calendar unit
// no dependencies
package esc_pkg;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ERA    = 10'b0000000010,
    S_YEAR   = 10'b0000000100,
    S_MONTH  = 10'b0000001000,
    S_DAY10  = 10'b0000010000,
    S_DAY1   = 10'b0000100000,
    S_HOUR10 = 10'b0001000000,
    S_HOUR1  = 10'b0010000000,
    S_MIN10  = 10'b0100000000,
    S_MIN1   = 10'b1000000000
  } esc_state_t;

  // a 400-year Gregorian cycle is always 146097 days, here in seconds
  localparam int unsigned  ERA_SECS_W     = 34;
  localparam logic [33:0]  ERA_SECS       = 34'd12622780800;
  // 400 years taken modulo 256
  localparam logic [7:0]   ERA_YEARS_LOW  = 8'd144;

  localparam logic [24:0]  COMMON_YEAR_SECS = 25'd31536000;
  localparam logic [24:0]  LEAP_YEAR_SECS   = 25'd31622400;

  localparam logic [21:0]  MONTH_31_SECS = 22'd2678400;
  localparam logic [21:0]  MONTH_30_SECS = 22'd2592000;
  localparam logic [21:0]  MONTH_29_SECS = 22'd2505600;
  localparam logic [21:0]  MONTH_28_SECS = 22'd2419200;

  // tens and units steps for the day, hour and minute walks
  localparam logic [19:0]  TEN_DAY_SECS  = 20'd864000;
  localparam logic [16:0]  DAY_SECS      = 17'd86400;
  localparam logic [15:0]  TEN_HOUR_SECS = 16'd36000;
  localparam logic [11:0]  HOUR_SECS     = 12'd3600;
  localparam logic [9:0]   TEN_MIN_SECS  = 10'd600;
  localparam logic [5:0]   MIN_SECS      = 6'd60;

  localparam logic [7:0]   EPOCH_YEARS_SINCE_1900 = 8'd70;
  // 1970 modulo 400
  localparam logic [8:0]   EPOCH_YEAR_MOD400      = 9'd370;
  localparam logic [8:0]   YEAR_MOD400_LAST       = 9'd399;

  localparam logic [3:0]   MONTH_JAN  = 4'd0;
  localparam logic [3:0]   MONTH_FEB  = 4'd1;
  localparam logic [3:0]   MONTH_LAST = 4'd11;

  // leap rule on the year taken modulo 400
  function automatic logic is_leap(input logic [8:0] ym400);
    logic by4;
    logic century;
    by4     = (ym400[1:0] == 2'b00);
    century = (ym400 == 9'd100) || (ym400 == 9'd200) || (ym400 == 9'd300);
    return by4 && !century;
  endfunction

  // seconds in a month, february follows the leap flag
  function automatic logic [21:0] month_secs(input logic [3:0] mon, input logic leap);
    logic [21:0] len;
    case (mon)
      4'd0:      len = MONTH_31_SECS;
      MONTH_FEB: len = leap ? MONTH_29_SECS : MONTH_28_SECS;
      4'd2:      len = MONTH_31_SECS;
      4'd3:      len = MONTH_30_SECS;
      4'd4:      len = MONTH_31_SECS;
      4'd5:      len = MONTH_30_SECS;
      4'd6:      len = MONTH_31_SECS;
      4'd7:      len = MONTH_31_SECS;
      4'd8:      len = MONTH_30_SECS;
      4'd9:      len = MONTH_31_SECS;
      4'd10:     len = MONTH_30_SECS;
      4'd11:     len = MONTH_31_SECS;
      default:   len = MONTH_31_SECS;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/epoch_seconds_to_calendar_unit.sv
// epoch seconds to utc calendar breakdown, one shared subtractor under a sequencer
// depends on esc_pkg and epoch_seconds_to_calendar_unit_macros.svh
//
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+-------------------------
//  input   | in_epoch_seconds                            | in_valid / in_stall
//  result  | out_years_since_1900, out_month_index,      | out_valid / out_stall
//          | out_day_of_month, out_hour_of_day,          |
//          | out_minute_of_hour, out_second_of_minute    |
//
// an item is taken in idle, then one subtract-compare per cycle works down the seconds
//   count: 400-year eras (one try at width 32), whole years (up to 137), months (up to 12),
//   then tens and units of days, hours and minutes (up to 41 together),
//   of which the year walk is the longest
// in_stall is high from acceptance until the result is loaded into the output register;
//   the last minute step waits only while the output register holds an untaken result
// rst_n is synchronous, active low, and clears the sequencer and out_valid
`include "epoch_seconds_to_calendar_unit_macros.svh"

module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
#(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SECONDS_WIDTH-1:0] in_epoch_seconds,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_years_since_1900,
  output logic [3:0]               out_month_index,
  output logic [4:0]               out_day_of_month,
  output logic [4:0]               out_hour_of_day,
  output logic [5:0]               out_minute_of_hour,
  output logic [5:0]               out_second_of_minute
);

  // subtractor width: wide enough for the count and the 400-year constant
  localparam int UW = (SECONDS_WIDTH > ERA_SECS_W) ? SECONDS_WIDTH : ERA_SECS_W;

  esc_state_t state_r, state_nxt;

  // seconds still to be walked off
  logic [SECONDS_WIDTH-1:0] acc_r, acc_nxt;
  logic [7:0]               yr_r, yr_nxt;     // years since 1900, low 8 bits
  logic [8:0]               ym400_r, ym400_nxt;
  logic [3:0]               mon_r, mon_nxt;
  logic [4:0]               day_r, day_nxt;   // day index from 0
  logic [4:0]               hour_r, hour_nxt;
  logic [5:0]               min_r, min_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_yr_r, out_yr_nxt;
  logic [3:0]               out_mon_r, out_mon_nxt;
  logic [4:0]               out_day_r, out_day_nxt;
  logic [4:0]               out_hour_r, out_hour_nxt;
  logic [5:0]               out_min_r, out_min_nxt;
  logic [5:0]               out_sec_r, out_sec_nxt;

  // shared subtract-compare unit
  logic [UW-1:0] op_a, op_b, diff;
  logic [UW:0]   sub_full;
  logic          ge;

  logic          leap;
  logic          out_free;
  logic          month_end;

  assign leap     = is_leap(ym400_r);
  assign out_free = !out_valid_r || !out_stall;

  // step size for the one subtractor, chosen by the walk in progress
  assign op_a = UW'(acc_r);

  always_comb begin
    op_b = '0;
    case (state_r)
      S_ERA:    op_b = UW'(ERA_SECS);
      S_YEAR:   op_b = leap ? UW'(LEAP_YEAR_SECS) : UW'(COMMON_YEAR_SECS);
      S_MONTH:  op_b = UW'(month_secs(mon_r, leap));
      S_DAY10:  op_b = UW'(TEN_DAY_SECS);
      S_DAY1:   op_b = UW'(DAY_SECS);
      S_HOUR10: op_b = UW'(TEN_HOUR_SECS);
      S_HOUR1:  op_b = UW'(HOUR_SECS);
      S_MIN10:  op_b = UW'(TEN_MIN_SECS);
      S_MIN1:   op_b = UW'(MIN_SECS);
      default:  op_b = '0;
    endcase
  end

  assign sub_full  = {1'b0, op_a} - {1'b0, op_b};
  assign ge        = !sub_full[UW];
  assign diff      = sub_full[UW-1:0];
  assign month_end = !ge || (mon_r == MONTH_LAST);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    yr_nxt        = yr_r;
    ym400_nxt     = ym400_r;
    mon_nxt       = mon_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_yr_nxt    = out_yr_r;
    out_mon_nxt   = out_mon_r;
    out_day_nxt   = out_day_r;
    out_hour_nxt  = out_hour_r;
    out_min_nxt   = out_min_r;
    out_sec_nxt   = out_sec_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt   = in_epoch_seconds;
          yr_nxt    = EPOCH_YEARS_SINCE_1900;
          ym400_nxt = EPOCH_YEAR_MOD400;
          state_nxt = S_ERA;
        end
      end
      S_ERA: begin
        // whole 400-year cycles leave the year modulo 400 unchanged
        if (ge) begin
          acc_nxt = diff[SECONDS_WIDTH-1:0];
          yr_nxt  = yr_r + ERA_YEARS_LOW;
        end else begin
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (ge) begin
          acc_nxt   = diff[SECONDS_WIDTH-1:0];
          yr_nxt    = yr_r + 8'd1;
          ym400_nxt = (ym400_r == YEAR_MOD400_LAST) ? 9'd0 : ym400_r + 9'd1;
        end else begin
          mon_nxt   = MONTH_JAN;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        // december takes whatever is left of the year
        if (month_end) begin
          day_nxt   = '0;
          state_nxt = S_DAY10;
        end else begin
          acc_nxt = diff[SECONDS_WIDTH-1:0];
          mon_nxt = mon_r + 4'd1;
        end
      end
      S_DAY10: begin
        if (ge) begin
          acc_nxt = diff[SECONDS_WIDTH-1:0];
          day_nxt = day_r + 5'd10;
        end else begin
          state_nxt = S_DAY1;
        end
      end
      S_DAY1: begin
        if (ge) begin
          acc_nxt = diff[SECONDS_WIDTH-1:0];
          day_nxt = day_r + 5'd1;
        end else begin
          hour_nxt  = '0;
          state_nxt = S_HOUR10;
        end
      end
      S_HOUR10: begin
        if (ge) begin
          acc_nxt  = diff[SECONDS_WIDTH-1:0];
          hour_nxt = hour_r + 5'd10;
        end else begin
          state_nxt = S_HOUR1;
        end
      end
      S_HOUR1: begin
        if (ge) begin
          acc_nxt  = diff[SECONDS_WIDTH-1:0];
          hour_nxt = hour_r + 5'd1;
        end else begin
          min_nxt   = '0;
          state_nxt = S_MIN10;
        end
      end
      S_MIN10: begin
        if (ge) begin
          acc_nxt = diff[SECONDS_WIDTH-1:0];
          min_nxt = min_r + 6'd10;
        end else begin
          state_nxt = S_MIN1;
        end
      end
      S_MIN1: begin
        if (ge) begin
          acc_nxt = diff[SECONDS_WIDTH-1:0];
          min_nxt = min_r + 6'd1;
        end else begin
          // what is left is the second; hold until the output register is free
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_yr_nxt    = yr_r;
            out_mon_nxt   = mon_r;
            out_day_nxt   = day_r + 5'd1;
            out_hour_nxt  = hour_r;
            out_min_nxt   = min_r;
            out_sec_nxt   = acc_r[5:0];
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    yr_r       <= yr_nxt;
    ym400_r    <= ym400_nxt;
    mon_r      <= mon_nxt;
    day_r      <= day_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    out_yr_r   <= out_yr_nxt;
    out_mon_r  <= out_mon_nxt;
    out_day_r  <= out_day_nxt;
    out_hour_r <= out_hour_nxt;
    out_min_r  <= out_min_nxt;
    out_sec_r  <= out_sec_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_years_since_1900 = out_yr_r;
  assign out_month_index      = out_mon_r;
  assign out_day_of_month     = out_day_r;
  assign out_hour_of_day      = out_hour_r;
  assign out_minute_of_hour   = out_min_r;
  assign out_second_of_minute = out_sec_r;

  // an accepted item always starts the era walk
  `ESC_ASSERT_NXT(a_start_walk, clk, rst_n, in_valid && !in_stall, state_r == S_ERA)
  // the month walk never passes december
  `ESC_ASSERT_IMP(a_month_range, clk, rst_n, state_r == S_MONTH, mon_r <= MONTH_LAST)
  // year modulo 400 stays in range during the year walk
  `ESC_ASSERT_IMP(a_ym400_range, clk, rst_n, state_r == S_YEAR, ym400_r <= YEAR_MOD400_LAST)
  // hours and minutes stay in range in the last walk
  `ESC_ASSERT_IMP(a_time_range, clk, rst_n, state_r == S_MIN1,
                  (hour_r < 5'd24) && (min_r < 6'd60))
  // a shown result is a real date
  `ESC_ASSERT_IMP(a_out_date, clk, rst_n, out_valid_r,
                  (out_mon_r <= MONTH_LAST) && (out_day_r != 5'd0) && (out_hour_r < 5'd24))

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for epoch_seconds_to_calendar_unit: directed dates, then random ones
// depends on esc_pkg and the rtl of the unit; the expected breakdown is computed here
module testbench;
  import esc_pkg::*;

  localparam int unsigned CLK_PERIOD = 4;
  // time left after the last expected result, so a late spurious one is still caught
  localparam int unsigned DRAIN_CYCLES = 300;
  // upper bound on the whole run in cycles, for the watchdog
  localparam int unsigned TIMEOUT_CYCLES = 5_000_000;
  localparam int unsigned SECONDS_PER_DAY = 86400;
  // last day index that still fits a 32-bit count (2106-02-07)
  localparam int unsigned LAST_DAY_32 = 49710;

  // one calendar breakdown, at the widths of the result ports
  typedef struct packed {
    logic [7:0] years_since_1900;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic [4:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
  } calendar_t;

  // what flavour of timestamp the random part asks for
  typedef enum int {
    PICK_ANY,
    PICK_DAY_BOUNDARY,
    PICK_NEW_YEAR,
    PICK_LEAP_DAY,
    PICK_RANGE_END
  } seconds_pick_t;

  // ---------------------------------------------------------------------------
  // expected dates, oldest first, with the calendar arithmetic that fills them
  // ---------------------------------------------------------------------------
  class calendar_checker;
    calendar_t   expected_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function bit is_gregorian_leap(input int unsigned year);
      return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
    endfunction

    static function int unsigned days_in_month(input logic [3:0] mon, input bit leap);
      case (mon)
        4'd1:                     return leap ? 29 : 28;
        4'd3, 4'd5, 4'd8, 4'd10:  return 30;
        default:                  return 31;
      endcase
    endfunction

    // whole years are walked off from 1970, then whole months of the year reached
    static function calendar_t calendar_from_seconds(input logic [31:0] secs);
      calendar_t       c;
      longint unsigned days;
      int unsigned     year;
      int unsigned     year_len;
      int unsigned     mon_len;
      logic [3:0]      mon;
      bit              leap;
      c.second_of_minute = 6'(secs % 60);
      c.minute_of_hour   = 6'((secs / 60) % 60);
      c.hour_of_day      = 5'((secs / 3600) % 24);
      days = secs / SECONDS_PER_DAY;
      year = 1970;
      year_len = is_gregorian_leap(year) ? 366 : 365;
      while (days >= year_len) begin
        days -= year_len;
        year++;
        year_len = is_gregorian_leap(year) ? 366 : 365;
      end
      leap = is_gregorian_leap(year);
      mon = MONTH_JAN;
      while (mon != MONTH_LAST) begin
        mon_len = days_in_month(mon, leap);
        if (days < mon_len) break;
        days -= mon_len;
        mon++;
      end
      c.years_since_1900 = 8'(year - 1900);
      c.month_index      = mon;
      c.day_of_month     = 5'(days + 1);
      return c;
    endfunction

    function void note_input(input logic [31:0] secs);
      expected_dates.push_back(calendar_from_seconds(secs));
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    function void compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input calendar_t got);
      calendar_t want;
      if (expected_dates.size() == 0) begin
        $error("result with no item outstanding: %0d-%0d-%0d %0d:%0d:%0d",
               got.years_since_1900, got.month_index, got.day_of_month,
               got.hour_of_day, got.minute_of_hour, got.second_of_minute);
        mismatches++;
        return;
      end
      want = expected_dates.pop_front();
      compare_field("years_since_1900", want.years_since_1900, got.years_since_1900);
      compare_field("month_index", 8'(want.month_index), 8'(got.month_index));
      compare_field("day_of_month", 8'(want.day_of_month), 8'(got.day_of_month));
      compare_field("hour_of_day", 8'(want.hour_of_day), 8'(got.hour_of_day));
      compare_field("minute_of_hour", 8'(want.minute_of_hour), 8'(got.minute_of_hour));
      compare_field("second_of_minute", 8'(want.second_of_minute),
                    8'(got.second_of_minute));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and the unit
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_years_since_1900;
  logic [3:0]  out_month_index;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;

  calendar_checker dates;
  // random gaps on both sides are only inserted while this is set
  bit              idling_on;
  // a long receiver hold, in cycles, asked for by the stimulus and taken up by the sink
  int unsigned     hold_request;
  logic [31:0]     directed_seconds[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  epoch_seconds_to_calendar_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_seconds     (in_epoch_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_years_since_1900 (out_years_since_1900),
    .out_month_index      (out_month_index),
    .out_day_of_month     (out_day_of_month),
    .out_hour_of_day      (out_hour_of_day),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_second_of_minute (out_second_of_minute)
  );

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes a short gap, now and then a long pause that
  // lands inside or after the walk of the previous item
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic longint unsigned days_before_year(input int unsigned year);
    longint unsigned days;
    days = 0;
    for (int unsigned y = 1970; y < year; y++)
      days += calendar_checker::is_gregorian_leap(y) ? 366 : 365;
    return days;
  endfunction

  // full-range counts keep every input bit toggling; the rest aim at the places where
  // the day, year and month walks turn over and at both ends of the range (wrap past 2^32 is a legal input too)
  function automatic logic [31:0] random_seconds();
    seconds_pick_t   pick;
    longint unsigned t;
    int unsigned     r;
    int unsigned     year;
    r = $urandom_range(0, 9);
    if (r < 4)      pick = PICK_ANY;
    else if (r < 6) pick = PICK_DAY_BOUNDARY;
    else if (r < 8) pick = PICK_NEW_YEAR;
    else if (r < 9) pick = PICK_LEAP_DAY;
    else            pick = PICK_RANGE_END;
    case (pick)
      PICK_ANY: t = $urandom;
      PICK_DAY_BOUNDARY: begin
        t = longint'($urandom_range(0, LAST_DAY_32)) * SECONDS_PER_DAY;
        t += ($urandom_range(0, 1) ? 0 : SECONDS_PER_DAY - 2) + $urandom_range(0, 1);
      end
      PICK_NEW_YEAR: begin
        // a second either side of midnight on the first of january
        year = $urandom_range(1970, 2106);
        t = days_before_year(year) * SECONDS_PER_DAY + 1 - $urandom_range(0, 2);
      end
      PICK_LEAP_DAY: begin
        // 28th of february and the next two days: to the 1st of march in a leap year, else the 2nd
        year = $urandom_range(1970, 2105);
        t = (days_before_year(year) + 58 + $urandom_range(0, 2)) * SECONDS_PER_DAY;
        t += $urandom_range(0, SECONDS_PER_DAY - 1);
      end
      default: begin
        if ($urandom_range(0, 1)) t = $urandom_range(0, 200000);
        else                      t = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      end
    endcase
    return t[31:0];
  endfunction

  // offer one item from a falling edge, hold it until taken, return on the next
  // falling edge with valid still high so a back-to-back item follows cleanly
  task automatic send_item(input logic [31:0] secs);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_epoch_seconds = secs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    dates.note_input(secs);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: directed dates, random phases, a long hold and a full drain
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dates            = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_epoch_seconds = '0;
    idling_on        = 1'b0;
    hold_request     = 0;
    directed_seconds = {
      32'd0,            // the epoch itself
      32'd1,
      32'd59,           // last second of the first minute
      32'd60,
      32'd3599,         // minute and hour carry
      32'd3600,
      32'd86399,        // end of the first day
      32'd86400,
      32'd68169600,     // 29th february 1972, first leap day
      32'd94694399,     // last second of a leap year
      32'd946684799,    // eve of 2000
      32'd951782400,    // 29th february 2000, century that is leap
      32'd951868799,
      32'd951868800,    // 1st march 2000
      32'd2147483647,   // signed 32-bit overflow point
      32'd2147483648,
      32'd4107542399,   // 28th february 2100, century that is not leap
      32'd4107542400,   // 1st march 2100
      32'h5555_5555,
      32'hAAAA_AAAA,
      32'hFFFF_FFFF     // largest count, 2106-02-07 06:28:15
    };
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_seconds[i]) send_item(directed_seconds[i]);

    idling_on = 1'b1;
    repeat (600) send_item(random_seconds());

    // receiver holds off for a long stretch while items keep coming, so the
    // output register and the sequencer both fill and in_stall stays high
    idling_on    = 1'b0;
    hold_request = 1500;
    repeat (12) send_item(random_seconds());

    // sender pauses until every outstanding date has been returned
    in_valid = 1'b0;
    while (dates.pending() != 0) @(negedge clk);

    // a stretch with no idling at all, then idling again to the end
    repeat (200) send_item(random_seconds());
    idling_on = 1'b1;
    repeat (470) send_item(random_seconds());
    in_valid = 1'b0;

    while (dates.pending() != 0) @(posedge clk);
    // anything spurious that turns up late still gets flagged by the sink
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (dates.mismatches == 0) begin
      $display("PASS epoch_seconds_to_calendar_unit");
    end else begin
      $display("FAIL epoch_seconds_to_calendar_unit");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result sink: checks on the rising edge, moves out_stall on the falling edge
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned r;
    calendar_t   got;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_years_since_1900, out_month_index, out_day_of_month,
                out_hour_of_day, out_minute_of_hour, out_second_of_minute};
        dates.check_result(got);
      end
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (idling_on) begin
          // short stalls are common, long ones rare enough to keep throughput up
          r = $urandom_range(0, 999);
          if (r < 60)      stall_left = $urandom_range(1, 6);
          else if (r < 62) stall_left = $urandom_range(40, 400);
        end
      end
    end
  end

  // hard stop in case the unit hangs
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL epoch_seconds_to_calendar_unit");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/epoch_seconds_to_calendar_unit.sv
tb/sv/testbench.sv
